// ===== rtl/sfla_pkg.sv =====
// Package for the size-class free-list allocator.
// Holds the size constants, status codes, state and request-kind enums and the memory entry type.
// No dependencies; every rtl module uses it.
`default_nettype none

package sfla_pkg;

    // Heap geometry and class constants.
    localparam int HEAP_BYTES_DEF  = 1048576;
    localparam int NUM_CLASSES     = 10;
    localparam int MIN_CLASS_BYTES = 128;
    localparam int MAX_CLASS_BYTES = 65536;
    localparam int HEADER_BYTES    = 8;
    localparam int HEAP_START      = 48;
    localparam int OFF_W           = 20;
    localparam int CLS_W           = 4;
    localparam int STAT_W          = 2;
    // Granule index width of a 20-bit payload offset.
    localparam int MAX_GRAN_W      = OFF_W - 3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_ALLOCATED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FREED     = 2'd1;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE = 2'd3;

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // What the execute state of a transaction has to do.
    typedef enum logic [2:0] {
        K_TOO_LARGE,
        K_POP,
        K_CARVE,
        K_EXHAUSTED,
        K_FREE,
        K_BAD_FREE
    } kind_t;

    // One block descriptor entry, indexed by payload granule.
    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [OFF_W-1:0] link;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/sfla_mem.sv =====
// Block descriptor memory: class and free-list link for every payload granule.
// Synchronous, one write port and one read port, registered read data.
// Depends on sfla_pkg.
`default_nettype none

module sfla_mem #(
    parameter int ADDR_W = 17
) (
    input  wire                  clk,
    input  wire                  rd_en,
    input  wire [ADDR_W-1:0]     rd_addr,
    output sfla_pkg::entry_t     rd_data,
    input  wire                  wr_en,
    input  wire [ADDR_W-1:0]     wr_addr,
    input  sfla_pkg::entry_t     wr_data
);

    localparam int DEPTH = 1 << ADDR_W;

    sfla_pkg::entry_t mem_r [DEPTH];
    sfla_pkg::entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_r[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_r[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/sfla_ctrl.sv =====
// Allocator controller: class selection, free-list heads, bump pointer and result register.
// Issues reads and write-backs to the block descriptor memory (sfla_mem).
// Depends on sfla_pkg.
`default_nettype none

module sfla_ctrl #(
    parameter int HEAP_BYTES = sfla_pkg::HEAP_BYTES_DEF,
    parameter int ADDR_W     = 17,
    parameter int BRK_W      = 21
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // Request side.
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire                              in_op,
    input  wire [sfla_pkg::OFF_W-1:0]        in_req_size,
    input  wire [sfla_pkg::OFF_W-1:0]        in_poff,
    // Result side.
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [sfla_pkg::OFF_W-1:0]       out_offset,
    output logic [sfla_pkg::CLS_W-1:0]       out_class,
    output logic [sfla_pkg::STAT_W-1:0]      out_status,
    // Descriptor memory.
    output logic                             mem_rd_en,
    output logic [ADDR_W-1:0]                mem_rd_addr,
    input  sfla_pkg::entry_t                 mem_rd_data,
    output logic                             mem_wr_en,
    output logic [ADDR_W-1:0]                mem_wr_addr,
    output sfla_pkg::entry_t                 mem_wr_data
);

    localparam int OFF_W = sfla_pkg::OFF_W;
    localparam int CLS_W = sfla_pkg::CLS_W;
    localparam int SUM_W = BRK_W + 1;
    localparam int CMP_W = (BRK_W > OFF_W) ? BRK_W : OFF_W;

    // Control and state registers.
    sfla_pkg::state_t          state_reg, state_next;
    sfla_pkg::kind_t           kind_reg, kind_next;
    logic [CLS_W-1:0]          cls_reg, cls_next;
    logic [OFF_W-1:0]          off_reg, off_next;
    logic [OFF_W-1:0]          heads_reg [sfla_pkg::NUM_CLASSES];
    logic [BRK_W-1:0]          break_reg, break_next;
    logic                      out_valid_reg, out_valid_next;
    logic [OFF_W-1:0]          out_offset_reg, out_offset_next;
    logic [CLS_W-1:0]          out_class_reg, out_class_next;
    logic [sfla_pkg::STAT_W-1:0] out_status_reg, out_status_next;

    // Head update request.
    logic                      head_we;
    logic [CLS_W-1:0]          head_idx;
    logic [OFF_W-1:0]          head_val;

    // Accept-cycle decode.
    logic [CLS_W-1:0]          cls_sel;
    logic [OFF_W-1:0]          head_sel;
    logic                      too_large;
    logic [SUM_W-1:0]          carve_end_sel;
    logic                      bad_free;

    // Execute-cycle values.
    logic                      proceed;
    logic [SUM_W-1:0]          carve_end;
    logic [BRK_W-1:0]          carve_poff;
    logic [CLS_W-1:0]          free_cls;

    // Smallest class that fits the request: ten independent compares.
    always_comb
    begin
        cls_sel = CLS_W'(sfla_pkg::NUM_CLASSES - 1);
        for (int i = sfla_pkg::NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (in_req_size <= OFF_W'(sfla_pkg::MIN_CLASS_BYTES << i))
            begin
                cls_sel = CLS_W'(i);
            end
        end
    end

    assign too_large = in_req_size > OFF_W'(sfla_pkg::MAX_CLASS_BYTES);
    assign head_sel  = heads_reg[cls_sel];

    // End of a carved block for the selected class, and the same for the held class.
    assign carve_end_sel = SUM_W'(break_reg) + SUM_W'(sfla_pkg::HEADER_BYTES)
                         + (SUM_W'(sfla_pkg::MIN_CLASS_BYTES) << cls_sel);
    assign carve_end     = SUM_W'(break_reg) + SUM_W'(sfla_pkg::HEADER_BYTES)
                         + (SUM_W'(sfla_pkg::MIN_CLASS_BYTES) << cls_reg);
    assign carve_poff    = break_reg + BRK_W'(sfla_pkg::HEADER_BYTES);

    // A free of an offset that cannot be a payload start is ignored.
    assign bad_free = (in_poff < OFF_W'(sfla_pkg::HEAP_START + sfla_pkg::HEADER_BYTES))
                   || (in_poff[2:0] != 3'd0)
                   || (CMP_W'(in_poff) >= CMP_W'(break_reg));

    // Classes out of range in a stored entry fall back to class zero.
    assign free_cls = (mem_rd_data.cls >= CLS_W'(sfla_pkg::NUM_CLASSES))
                    ? '0 : mem_rd_data.cls;

    assign proceed = !out_valid_reg || out_ready;

    // Next state, memory requests and result values.
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        cls_next        = cls_reg;
        off_next        = off_reg;
        break_next      = break_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_offset_next = out_offset_reg;
        out_class_next  = out_class_reg;
        out_status_next = out_status_reg;
        in_ready        = 1'b0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = in_poff[ADDR_W+2:3];
        mem_wr_en       = 1'b0;
        mem_wr_addr     = off_reg[ADDR_W+2:3];
        mem_wr_data     = mem_rd_data;
        head_we         = 1'b0;
        head_idx        = cls_reg;
        head_val        = off_reg;

        case (state_reg)
            sfla_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = sfla_pkg::S_EXEC;
                    if (in_op == sfla_pkg::OP_FREE)
                    begin
                        cls_next = '0;
                        off_next = in_poff;
                        if (bad_free)
                        begin
                            kind_next = sfla_pkg::K_BAD_FREE;
                        end
                        else
                        begin
                            kind_next   = sfla_pkg::K_FREE;
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = in_poff[ADDR_W+2:3];
                        end
                    end
                    else if (too_large)
                    begin
                        kind_next = sfla_pkg::K_TOO_LARGE;
                        cls_next  = '0;
                        off_next  = '0;
                    end
                    else
                    begin
                        cls_next = cls_sel;
                        off_next = head_sel;
                        if (head_sel != '0)
                        begin
                            kind_next   = sfla_pkg::K_POP;
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = head_sel[ADDR_W+2:3];
                        end
                        else if (carve_end_sel > SUM_W'(HEAP_BYTES))
                        begin
                            kind_next = sfla_pkg::K_EXHAUSTED;
                        end
                        else
                        begin
                            kind_next = sfla_pkg::K_CARVE;
                        end
                    end
                end
            end

            sfla_pkg::S_EXEC:
            begin
                if (proceed)
                begin
                    state_next     = sfla_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                    out_class_next = cls_reg;
                    case (kind_reg)
                        sfla_pkg::K_POP:
                        begin
                            head_we         = 1'b1;
                            head_val        = mem_rd_data.link;
                            out_offset_next = off_reg;
                            out_status_next = sfla_pkg::ST_ALLOCATED;
                        end
                        sfla_pkg::K_CARVE:
                        begin
                            // Offsets past the 20-bit range can never be freed.
                            mem_wr_en        = (carve_poff >> OFF_W) == '0;
                            mem_wr_addr      = carve_poff[ADDR_W+2:3];
                            mem_wr_data.cls  = cls_reg;
                            mem_wr_data.link = '0;
                            break_next       = carve_end[BRK_W-1:0];
                            out_offset_next  = OFF_W'(carve_poff);
                            out_status_next  = sfla_pkg::ST_ALLOCATED;
                        end
                        sfla_pkg::K_EXHAUSTED:
                        begin
                            out_offset_next = '0;
                            out_status_next = sfla_pkg::ST_EXHAUSTED;
                        end
                        sfla_pkg::K_FREE:
                        begin
                            // Push: the block links to the old head, the head becomes the block.
                            mem_wr_en        = 1'b1;
                            mem_wr_addr      = off_reg[ADDR_W+2:3];
                            mem_wr_data.cls  = mem_rd_data.cls;
                            mem_wr_data.link = heads_reg[free_cls];
                            head_we          = 1'b1;
                            head_idx         = free_cls;
                            head_val         = off_reg;
                            out_offset_next  = off_reg;
                            out_class_next   = free_cls;
                            out_status_next  = sfla_pkg::ST_FREED;
                        end
                        sfla_pkg::K_BAD_FREE:
                        begin
                            out_offset_next = '0;
                            out_class_next  = '0;
                            out_status_next = sfla_pkg::ST_FREED;
                        end
                        default:
                        begin
                            out_offset_next = '0;
                            out_class_next  = '0;
                            out_status_next = sfla_pkg::ST_TOO_LARGE;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = sfla_pkg::S_IDLE;
            end
        endcase
    end

    // State, result-valid and bump-pointer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfla_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            break_reg     <= BRK_W'(sfla_pkg::HEAP_START);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            break_reg     <= break_next;
        end
    end

    // Free-list heads; zero marks an empty list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sfla_pkg::NUM_CLASSES; i++)
            begin
                heads_reg[i] <= '0;
            end
        end
        else if (head_we)
        begin
            heads_reg[head_idx] <= head_val;
        end
    end

    // Transaction and result payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        cls_reg        <= cls_next;
        off_reg        <= off_next;
        out_offset_reg <= out_offset_next;
        out_class_reg  <= out_class_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_offset = out_offset_reg;
    assign out_class  = out_class_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

// ===== rtl/size_class_free_list_allocator_top.sv =====
// Top level of the size-class free-list allocator.
// Instantiates the controller (sfla_ctrl) and the block descriptor memory (sfla_mem).
// Depends on sfla_pkg.
//
//  Channel   Direction  tdata (low bit up)                 tuser
//  s_axis    in         request_size[19:0], payload_offset  operation[0]
//  m_axis    out        block_offset[19:0], size_class[3:0] status[1:0]
//
// Each transaction has an accept step, which picks the class and reads the descriptor
// memory, and an execute step, which writes the entry back and loads the result register.
// s_axis_tready is high only while no transaction is in progress; a result held on a stalled
// m_axis holds the execute step; a new request waits until the last one is done.
// Reset clears the free-list heads and sets the bump pointer to 48; the memory needs no clear.
`default_nettype none

module size_class_free_list_allocator_top #(
    parameter int HEAP_BYTES = sfla_pkg::HEAP_BYTES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // request_size[19:0], payload_offset[39:20]
    input  wire  [0:0]  s_axis_tuser,   // operation[0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // block_offset[19:0], size_class[23:20]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int HEAP_W = $clog2(HEAP_BYTES);
    localparam int BRK_W  = HEAP_W + 1;
    localparam int ADDR_W = (HEAP_W - 3 < sfla_pkg::MAX_GRAN_W)
                          ? (HEAP_W - 3) : sfla_pkg::MAX_GRAN_W;

    logic                          mem_rd_en;
    logic [ADDR_W-1:0]             mem_rd_addr;
    sfla_pkg::entry_t              mem_rd_data;
    logic                          mem_wr_en;
    logic [ADDR_W-1:0]             mem_wr_addr;
    sfla_pkg::entry_t              mem_wr_data;
    logic [sfla_pkg::OFF_W-1:0]    out_offset;
    logic [sfla_pkg::CLS_W-1:0]    out_class;
    logic [sfla_pkg::STAT_W-1:0]   out_status;

    // Controller.
    sfla_ctrl #(
        .HEAP_BYTES (HEAP_BYTES),
        .ADDR_W     (ADDR_W),
        .BRK_W      (BRK_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (s_axis_tuser[0]),
        .in_req_size (s_axis_tdata[19:0]),
        .in_poff     (s_axis_tdata[39:20]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_offset  (out_offset),
        .out_class   (out_class),
        .out_status  (out_status),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    // Block descriptor memory.
    sfla_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // Pack the result transaction.
    assign m_axis_tdata = {out_class, out_offset};
    assign m_axis_tuser = out_status;

endmodule

`default_nettype wire
